// ----- rtl/bb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb_pkg
// Shared types, status codes and default parameters of the buddy allocator.
// ----------------------------------------------------------------------------
package bb_pkg;

	localparam int MIN_ORDER_DEF     = 7;
	localparam int MAX_SEG_ORDER_DEF = 18;
	localparam int MAX_PAYLOAD_DEF   = 4096;
	localparam int HEADER_BYTES_DEF  = 24;

	localparam int SEG_ORDER_RESET = 15;
	localparam int CFG_W           = 5;
	localparam int SIZE_W          = 16;
	localparam int OFFSET_W        = 18;
	localparam int STATUS_W        = 2;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd3;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef struct packed {
		logic                req_type;
		logic [SIZE_W-1:0]   req_size;
		logic [OFFSET_W-1:0] free_offset;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [OFFSET_W-1:0] payload_offset;
		logic [CFG_W-1:0]    block_order;
	} rsp_t;

endpackage

// ----- rtl/buddy_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_allocator
// Binary buddy allocator over a power-of-two segment, slot state in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//  in_*  : request channel (valid/stall). One request per transfer: allocate
//          or free. in_stall is low only while the engine is idle.
//  out_* : result channel (valid/stall). Exactly one result per request,
//          held in an output register; a new request is taken while a result
//          still waits for the receiver.
//  cfg_* : segment order write (valid/ready), taken only while the engine is
//          idle with no request offered or is clearing. A write reinitialises
//          the segment to one free block and starts a clearing pass.
// Sequence: a rejected request goes straight to its result. An allocate walks
//  every block of the segment, up to 2^(MAX_SEG_ORDER-MIN_ORDER) blocks, then
//  splits the best fit down to size. A free checks the offset and the slot,
//  then merges with its buddy while that is free and of equal order.
// Reset and configuration: after reset or a segment order write the slot RAM
//  is cleared one entry a cycle, all 2^(MAX_SEG_ORDER-MIN_ORDER) entries,
//  while no request is taken.
// Stall: a finished result waits in the engine until the output register is
//  free; the engine takes no new request during that wait.
// ----------------------------------------------------------------------------
module buddy_allocator
	import bb_pkg::*;
#(
	parameter int MIN_ORDER     = MIN_ORDER_DEF,
	parameter int MAX_SEG_ORDER = MAX_SEG_ORDER_DEF,
	parameter int MAX_PAYLOAD   = MAX_PAYLOAD_DEF,
	parameter int HEADER_BYTES  = HEADER_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  req_t             in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output rsp_t             out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int SW     = MAX_SEG_ORDER - MIN_ORDER;
	localparam int IW     = SW + 1;
	localparam int NSLOTS = 1 << SW;
	localparam int ORD_W  = $clog2(SW + 1);
	localparam int ENT_W  = ORD_W + 2;

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_A_PRE  = 4'd2;
	localparam logic [3:0] S_A_RD   = 4'd3;
	localparam logic [3:0] S_A_EVAL = 4'd4;
	localparam logic [3:0] S_A_SPL  = 4'd5;
	localparam logic [3:0] S_F_PRE  = 4'd6;
	localparam logic [3:0] S_F_CHK  = 4'd7;
	localparam logic [3:0] S_M_TEST = 4'd8;
	localparam logic [3:0] S_M_EVAL = 4'd9;
	localparam logic [3:0] S_DONE   = 4'd10;

	logic [3:0]       state_q;
	logic [CFG_W-1:0] seg_q;
	logic [IW-1:0]    clr_q;
	req_t             req_q;
	logic [IW-1:0]    i_q;
	logic [SW-1:0]    best_q;
	logic [ORD_W-1:0] best_ord_q;
	logic             found_q;
	logic [ORD_W-1:0] need_q;
	logic [SW-1:0]    slot_q;
	logic [ORD_W-1:0] ord_q;
	rsp_t             res_q;
	rsp_t             out_q;
	logic             out_valid_q;

	logic             we_c;
	logic [SW-1:0]    wa_c;
	logic [ENT_W-1:0] wd_c;
	logic [SW-1:0]    ra_c;
	logic [ENT_W-1:0] rd_c;

	logic             rd_start, rd_used;
	logic [ORD_W-1:0] rd_ord;
	assign rd_start = rd_c[ENT_W-1];
	assign rd_used  = rd_c[ENT_W-2];
	assign rd_ord   = rd_c[ORD_W-1:0];

	logic [ORD_W-1:0] seg_rel;
	logic [IW-1:0]    limit;
	assign seg_rel = ORD_W'(seg_q - CFG_W'(MIN_ORDER));
	assign limit   = IW'(1) << seg_rel;

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = ((state_q == S_IDLE) && !in_valid) || (state_q == S_CLEAR);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Clamp the written segment order into the supported range.
	logic [CFG_W-1:0] cfg_clamp;
	always_comb begin
		cfg_clamp = cfg_data;
		if (32'(cfg_data) < MIN_ORDER) begin
			cfg_clamp = CFG_W'(MIN_ORDER);
		end else if (32'(cfg_data) > MAX_SEG_ORDER) begin
			cfg_clamp = CFG_W'(MAX_SEG_ORDER);
		end
	end

	// Allocate: range check and rounded order of size plus header.
	logic [SIZE_W:0]  need_bytes;
	logic             range_bad;
	logic             ord_found;
	logic [ORD_W-1:0] need_ord;
	always_comb begin
		need_bytes = (SIZE_W + 1)'(req_q.req_size) + (SIZE_W + 1)'(HEADER_BYTES);
		range_bad  = (32'(req_q.req_size) < (32'(1) << MIN_ORDER)) ||
		             (32'(req_q.req_size) > MAX_PAYLOAD);
		ord_found  = 1'b0;
		need_ord   = '0;
		for (int k = 0; k <= SW; k++) begin
			if (!ord_found && (32'(need_bytes) <= (32'(1) << (MIN_ORDER + k)))) begin
				ord_found = 1'b1;
				need_ord  = ORD_W'(k);
			end
		end
	end

	// Free: offset checks and slot index.
	logic [31:0] rel32;
	logic [31:0] slot32;
	logic        free_bad;
	always_comb begin
		rel32    = 32'(req_q.free_offset) - 32'(HEADER_BYTES);
		slot32   = rel32 >> MIN_ORDER;
		free_bad = (32'(req_q.free_offset) < HEADER_BYTES) ||
		           (rel32[MIN_ORDER-1:0] != '0) ||
		           (slot32 >= (32'(1) << seg_rel));
	end

	// Walk evaluation of the block just read.
	logic [ORD_W-1:0] walk_ord;
	logic             walk_take;
	logic [IW-1:0]    walk_nxt;
	always_comb begin
		walk_ord  = (rd_ord > seg_rel) ? '0 : rd_ord;
		walk_take = !rd_used && (walk_ord >= need_q) &&
		            (!found_q || (walk_ord < best_ord_q));
		walk_nxt  = i_q + (IW'(1) << walk_ord);
	end

	// Buddy of the current block and merge decision.
	logic [SW-1:0]    split_half;
	logic [ORD_W-1:0] split_ord;
	logic [SW-1:0]    buddy;
	logic             merge_ok;
	logic [SW-1:0]    m_low, m_high;
	always_comb begin
		split_ord  = best_ord_q - ORD_W'(1);
		split_half = best_q + (SW'(1) << split_ord);
		buddy      = slot_q ^ (SW'(1) << ord_q);
		merge_ok   = rd_start && !rd_used && (rd_ord == ord_q);
		m_low      = (slot_q < buddy) ? slot_q : buddy;
		m_high     = (slot_q < buddy) ? buddy : slot_q;
	end

	// Result word for a good outcome.
	function automatic rsp_t ok_rsp(input logic [SW-1:0] s, input logic [ORD_W-1:0] o);
		rsp_t r;
		logic [31:0] off;
		off              = (32'(s) << MIN_ORDER) + 32'(HEADER_BYTES);
		r.status         = ST_OK;
		r.payload_offset = off[OFFSET_W-1:0];
		r.block_order    = CFG_W'(32'(o) + MIN_ORDER);
		return r;
	endfunction

	function automatic rsp_t err_rsp(input logic [STATUS_W-1:0] st);
		rsp_t r;
		r                = '0;
		r.status         = st;
		return r;
	endfunction

	// RAM port control.
	always_comb begin
		we_c = 1'b0;
		wa_c = '0;
		wd_c = '0;
		ra_c = slot_q;
		unique case (state_q)
			S_CLEAR: begin
				we_c = 1'b1;
				wa_c = clr_q[SW-1:0];
				wd_c = (clr_q == '0) ? {1'b1, 1'b0, seg_rel} : '0;
			end
			S_A_RD:   ra_c = i_q[SW-1:0];
			S_A_SPL: begin
				we_c = 1'b1;
				if (best_ord_q > need_q) begin
					wa_c = split_half;
					wd_c = {1'b1, 1'b0, split_ord};
				end else begin
					wa_c = best_q;
					wd_c = {1'b1, 1'b1, best_ord_q};
				end
			end
			S_F_PRE:  ra_c = SW'(slot32);
			S_M_TEST: begin
				ra_c = buddy;
				if (ord_q >= seg_rel) begin
					we_c = 1'b1;
					wa_c = slot_q;
					wd_c = {1'b1, 1'b0, ord_q};
				end
			end
			S_M_EVAL: begin
				we_c = 1'b1;
				if (merge_ok) begin
					wa_c = m_high;
					wd_c = '0;
				end else begin
					wa_c = slot_q;
					wd_c = {1'b1, 1'b0, ord_q};
				end
			end
			default: ;
		endcase
	end

	bb_ram #(
		.WIDTH(ENT_W),
		.DEPTH(NSLOTS)
	) u_slots (
		.clk  (clk),
		.we   (we_c),
		.waddr(wa_c),
		.wdata(wd_c),
		.raddr(ra_c),
		.rdata(rd_c)
	);

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			seg_q       <= CFG_W'(SEG_ORDER_RESET);
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(NSLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (in_data.req_type == REQ_FREE) ? S_F_PRE : S_A_PRE;
					end
				end
				S_A_PRE: begin
					if (range_bad) begin
						state_q <= S_DONE;
					end else if (!ord_found || (need_ord > seg_rel)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_A_RD;
					end
				end
				S_A_RD:   state_q <= S_A_EVAL;
				S_A_EVAL: begin
					if (walk_nxt >= limit) begin
						state_q <= (found_q || walk_take) ? S_A_SPL : S_DONE;
					end else begin
						state_q <= S_A_RD;
					end
				end
				S_A_SPL: begin
					if (best_ord_q <= need_q) begin
						state_q <= S_DONE;
					end
				end
				S_F_PRE:  state_q <= free_bad ? S_DONE : S_F_CHK;
				S_F_CHK:  state_q <= (rd_start && rd_used) ? S_M_TEST : S_DONE;
				S_M_TEST: state_q <= (ord_q >= seg_rel) ? S_DONE : S_M_EVAL;
				S_M_EVAL: state_q <= merge_ok ? S_M_TEST : S_DONE;
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
			// A segment write restarts the clearing pass.
			if (cfg_valid && cfg_ready) begin
				seg_q   <= cfg_clamp;
				clr_q   <= '0;
				state_q <= S_CLEAR;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				req_q   <= in_data;
				i_q     <= '0;
				found_q <= 1'b0;
			end
			S_A_PRE: begin
				need_q <= need_ord;
				if (range_bad) begin
					res_q <= err_rsp(ST_RANGE);
				end else begin
					res_q <= err_rsp(ST_NOSPACE);
				end
			end
			S_A_EVAL: begin
				i_q <= walk_nxt;
				if (walk_take) begin
					found_q    <= 1'b1;
					best_q     <= i_q[SW-1:0];
					best_ord_q <= walk_ord;
				end
			end
			S_A_SPL: begin
				if (best_ord_q > need_q) begin
					best_ord_q <= split_ord;
				end else begin
					res_q <= ok_rsp(best_q, best_ord_q);
				end
			end
			S_F_PRE: begin
				slot_q <= SW'(slot32);
				res_q  <= err_rsp(ST_BADFREE);
			end
			S_F_CHK:  ord_q <= rd_ord;
			S_M_TEST: begin
				if (ord_q >= seg_rel) begin
					res_q <= ok_rsp(slot_q, ord_q);
				end
			end
			S_M_EVAL: begin
				if (merge_ok) begin
					slot_q <= m_low;
					ord_q  <= ord_q + ORD_W'(1);
				end else begin
					res_q <= ok_rsp(slot_q, ord_q);
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/bb_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- dv/tb_buddy_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buddy_allocator
// Self-checking bench for the buddy allocator: a behavioural model of the slot
// map predicts every result, random and directed allocate/free traffic runs
// under several segment orders with random idling and back-pressure.
// ----------------------------------------------------------------------------
module tb_buddy_allocator;
	import bb_pkg::*;

	localparam int MIN_ORD  = MIN_ORDER_DEF;
	localparam int MAX_ORD  = MAX_SEG_ORDER_DEF;
	localparam int HDR      = HEADER_BYTES_DEF;
	localparam int MAX_PLD  = MAX_PAYLOAD_DEF;
	localparam int N_SLOTS  = 1 << (MAX_ORD - MIN_ORD);
	localparam int SETTLE   = 60;   // cycles of quiet after the last result
	localparam int HOLD_LEN = 600;  // long receiver hold-off

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	req_t             in_data;
	logic             out_valid;
	logic             out_stall;
	rsp_t             out_data;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data;

	// slot map model
	int          seg_order;
	logic [4:0]  slot_ord[N_SLOTS];
	bit          slot_busy[N_SLOTS];
	bit          slot_head[N_SLOTS];
	int          live_offs[$];      // payload offsets currently allocated
	int          freed_offs[$];     // offsets freed earlier, for double frees
	rsp_t        pending_rsp[$];    // results still owed by the block

	int send_idle_pct;
	int stall_pct;
	int hold_req;
	int errors;

	buddy_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Reinitialise the slot map to one free block of the whole segment.
	task automatic clear_map(int ord);
		seg_order = ord;
		for (int i = 0; i < N_SLOTS; i++) begin
			slot_ord[i]  = '0;
			slot_busy[i] = 1'b0;
			slot_head[i] = 1'b0;
		end
		slot_ord[0]  = 5'(ord);
		slot_head[0] = 1'b1;
		live_offs.delete();
		freed_offs.delete();
	endtask

	function automatic rsp_t error_rsp(logic [STATUS_W-1:0] st);
		rsp_t r;
		r.status         = st;
		r.payload_offset = '0;
		r.block_order    = '0;
		return r;
	endfunction

	function automatic rsp_t ok_rsp(int slot, int ord);
		rsp_t r;
		r.status         = ST_OK;
		r.payload_offset = OFFSET_W'((slot << MIN_ORD) + HDR);
		r.block_order    = 5'(ord);
		return r;
	endfunction

	// Smallest free block that fits, leftmost on ties, split down to size.
	function automatic rsp_t allocate_block(int size);
		int need, ord, i, o, best, best_ord, half;
		bit found;
		found = 1'b0;
		best = 0;
		best_ord = 0;
		if (size < (1 << MIN_ORD) || size > MAX_PLD)
			return error_rsp(ST_RANGE);
		need = size + HDR;
		ord = MIN_ORD;
		while ((1 << ord) < need)
			ord++;
		if (ord > seg_order)
			return error_rsp(ST_NOSPACE);
		i = 0;
		while (i < (1 << (seg_order - MIN_ORD))) begin
			o = slot_ord[i];
			if (o < MIN_ORD || o > seg_order)
				o = MIN_ORD;
			if (!slot_busy[i] && o >= ord && (!found || o < best_ord)) begin
				found = 1'b1;
				best = i;
				best_ord = o;
			end
			i += 1 << (o - MIN_ORD);
		end
		if (!found)
			return error_rsp(ST_NOSPACE);
		while (best_ord > ord) begin
			best_ord--;
			half = (best + (1 << (best_ord - MIN_ORD))) % N_SLOTS;
			slot_head[half] = 1'b1;
			slot_busy[half] = 1'b0;
			slot_ord[half]  = 5'(best_ord);
		end
		slot_ord[best]  = 5'(best_ord);
		slot_busy[best] = 1'b1;
		live_offs.push_back((best << MIN_ORD) + HDR);
		return ok_rsp(best, best_ord);
	endfunction

	// Release a block and merge with equal-order free buddies.
	function automatic rsp_t release_block(int off);
		int rel, slot, ord, buddy, lo, hi;
		if (off < HDR)
			return error_rsp(ST_BADFREE);
		rel = off - HDR;
		if (rel % (1 << MIN_ORD) != 0)
			return error_rsp(ST_BADFREE);
		slot = rel >> MIN_ORD;
		if (slot >= (1 << (seg_order - MIN_ORD)) || !slot_head[slot] || !slot_busy[slot])
			return error_rsp(ST_BADFREE);
		foreach (live_offs[k])
			if (live_offs[k] == off) begin
				live_offs.delete(k);
				break;
			end
		freed_offs.push_back(off);
		slot_busy[slot] = 1'b0;
		ord = slot_ord[slot];
		while (ord < seg_order) begin
			buddy = (slot ^ (1 << (ord - MIN_ORD))) % N_SLOTS;
			if (!slot_head[buddy] || slot_busy[buddy] || slot_ord[buddy] != ord)
				break;
			lo = slot < buddy ? slot : buddy;
			hi = slot < buddy ? buddy : slot;
			slot_head[hi] = 1'b0;
			slot_ord[hi]  = '0;
			slot_busy[hi] = 1'b0;
			ord++;
			slot = lo;
			slot_ord[slot]  = 5'(ord);
			slot_busy[slot] = 1'b0;
		end
		return ok_rsp(slot, ord);
	endfunction

	// Offer one request, hold it until the transfer, then idle at random.
	// Valid stays high when no gap follows; end_burst lowers it.
	task automatic send_req(logic kind, int size, int off);
		req_t r;
		r.req_type    = kind;
		r.req_size    = SIZE_W'(size);
		r.free_offset = OFFSET_W'(off);
		in_valid <= 1'b1;
		in_data  <= r;
		do
			@(posedge clk);
		while (in_stall);
		if (kind == REQ_ALLOC)
			pending_rsp.push_back(allocate_block(size));
		else
			pending_rsp.push_back(release_block(off));
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		wait (pending_rsp.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write the segment order while idle; mirror the clamp in the model.
	task automatic write_seg_order(int value);
		int v;
		end_burst();
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= CFG_W'(value);
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		v = value;
		if (v < MIN_ORD)
			v = MIN_ORD;
		if (v > MAX_ORD)
			v = MAX_ORD;
		clear_map(v);
	endtask

	// Mostly sane traffic (allocs and frees of live blocks), some noise.
	task automatic send_mixed(int n, int max_size);
		int roll, pick;
		for (int k = 0; k < n; k++) begin
			roll = $urandom_range(99);
			if (live_offs.size() > 0 && roll < 40) begin
				pick = live_offs[$urandom_range(live_offs.size() - 1)];
				send_req(REQ_FREE, $urandom, pick);
			end else if (freed_offs.size() > 0 && roll < 44) begin
				pick = freed_offs[$urandom_range(freed_offs.size() - 1)];
				send_req(REQ_FREE, $urandom, pick);
			end else if (roll < 48) begin
				send_req(REQ_FREE, $urandom, $urandom_range(262143));
			end else if (roll < 51) begin
				send_req(REQ_FREE, $urandom, ($urandom_range(2047) << MIN_ORD) + HDR);
			end else if (roll < 55) begin
				send_req(REQ_ALLOC, $urandom_range(1) ? $urandom_range(127)
					: $urandom_range(65535, MAX_PLD + 1), $urandom);
			end else if (roll < 62) begin
				send_req(REQ_ALLOC, $urandom_range(MAX_PLD, 128), $urandom);
			end else begin
				send_req(REQ_ALLOC, $urandom_range(max_size, 128), $urandom);
			end
		end
	endtask

	// Size and offset extremes, the range and bad-free error paths, a full merge back.
	task automatic test_directed();
		int a, b;
		send_idle_pct = 0;
		stall_pct = 0;
		send_req(REQ_ALLOC, 0, 0);
		send_req(REQ_ALLOC, 127, 0);
		send_req(REQ_ALLOC, 4097, 0);
		send_req(REQ_ALLOC, 65535, 262143);
		send_req(REQ_ALLOC, 128, 0);
		send_req(REQ_ALLOC, 104 + 1, 0);
		send_req(REQ_ALLOC, 232, 0);
		send_req(REQ_ALLOC, 233, 0);
		send_req(REQ_ALLOC, 4072, 0);
		send_req(REQ_ALLOC, 4096, 0);
		send_req(REQ_FREE, 0, 0);
		send_req(REQ_FREE, 0, 23);
		send_req(REQ_FREE, 0, 25);
		send_req(REQ_FREE, 0, 262143);
		send_req(REQ_FREE, 65535, (1 << 15) + HDR);
		send_req(REQ_FREE, 0, 128 + HDR);
		a = live_offs[0];
		b = live_offs[1];
		send_req(REQ_FREE, 0, b);
		send_req(REQ_FREE, 0, b);
		while (live_offs.size() > 0)
			send_req(REQ_FREE, 0, live_offs[0]);
		send_req(REQ_FREE, 0, a);
		end_burst();
	endtask

	// Clamped values, both extremes and a tiny segment with no room at all.
	task automatic test_seg_orders();
		write_seg_order(0);
		send_req(REQ_ALLOC, 128, 0);
		send_req(REQ_FREE, 0, HDR);
		write_seg_order(8);
		send_req(REQ_ALLOC, 128, 0);
		send_req(REQ_ALLOC, 128, 0);
		send_req(REQ_FREE, 0, HDR);
		write_seg_order(31);
		send_req(REQ_ALLOC, 4096, 0);
		send_req(REQ_FREE, 0, (1 << 17) + HDR);
		send_req(REQ_FREE, 0, HDR);
		write_seg_order(MAX_ORD);
		send_mixed(20, 4096);
		write_seg_order(MIN_ORD);
		send_mixed(10, 300);
		end_burst();
	endtask

	// One random phase per idling mix, each on a fresh segment order.
	task automatic test_random_phase(int idle, int stall, int n);
		send_idle_pct = idle;
		stall_pct = stall;
		write_seg_order($urandom_range(13, 9));
		send_mixed(n / 2, 600);
		write_seg_order($urandom_range(16, 11));
		send_mixed(n - n / 2, 1500);
		end_burst();
	endtask

	// Hold the receiver off long enough for the block to fill and stall.
	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		write_seg_order(12);
		hold_req++;
		send_mixed(30, 500);
		end_burst();
	endtask

	// Sender waits for every result, then resumes.
	task automatic test_drain_pause();
		send_idle_pct = 30;
		stall_pct = 30;
		send_mixed(20, 800);
		end_burst();
		wait_drained();
		send_mixed(20, 800);
		end_burst();
	endtask

	// Receiver: random stalls, plus a long hold-off when one is requested.
	initial begin : stall_ctrl
		int hold_seen, hold_left;
		hold_seen = 0;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Compare every result transfer with the oldest expectation.
	always @(posedge clk) begin
		rsp_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_rsp.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected result st=%0d off=%0d ord=%0d", $realtime,
						out_data.status, out_data.payload_offset, out_data.block_order);
			end else begin
				exp_r = pending_rsp.pop_front();
				if (out_data.status !== exp_r.status
						|| out_data.payload_offset !== exp_r.payload_offset
						|| out_data.block_order !== exp_r.block_order) begin
					errors++;
					if (errors <= 10)
						$display("%0t: mismatch exp st=%0d off=%0d ord=%0d got st=%0d off=%0d ord=%0d",
							$realtime, exp_r.status, exp_r.payload_offset, exp_r.block_order,
							out_data.status, out_data.payload_offset, out_data.block_order);
				end
			end
		end
	end

	initial begin
		#60ms;
		$display("** buddy_allocator: FAILED **");
		$finish;
	end

	initial begin
		errors = 0;
		hold_req = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		clear_map(SEG_ORDER_RESET);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_seg_orders();
		test_random_phase(0, 0, 380);
		test_random_phase(77, 0, 380);
		test_random_phase(0, 77, 380);
		test_random_phase(19, 19, 380);
		test_backpressure();
		test_drain_pause();

		wait_drained();
		if (errors == 0)
			$display("** buddy_allocator: PASSED **");
		else
			$display("** buddy_allocator: FAILED **");
		$finish;
	end

endmodule
